### rtl/srq_pkg.sv
package srq_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  item_priority;
        logic [15:0] item_pid;
        logic [3:0]  position;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] read_pid;
        logic [7:0]  read_priority;
        logic [4:0]  entry_count;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CMP,
        S_REM_RD,
        S_REM_CMP,
        S_RD_WAIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        ADDR_PREV,
        ADDR_IDX,
        ADDR_POS
    } addr_sel_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        addr_sel_t  rd_sel;
        logic       wr_new;
        logic       wr_shift_up;
        logic       wr_shift_down;
        logic       idx_inc;
        logic       idx_dec;
        logic       found_set;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       fin;
        logic       fin_read;
        logic [1:0] fin_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       pos_oob;
        logic       idx_zero;
        logic       idx_at_count;
        logic       less;
        logic       pid_match;
        logic       found;
    } dp_status_t;

endpackage

### rtl/srq_ctrl.sv
module srq_ctrl
    import srq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (dp_status.action)
                    ACT_INSERT: state_next = dp_status.full ? S_IDLE : S_INS_RD;
                    ACT_REMOVE: state_next = S_REM_RD;
                    ACT_READ:   state_next = dp_status.pos_oob ? S_IDLE : S_RD_WAIT;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_INS_RD:  state_next = dp_status.idx_zero ? S_IDLE : S_INS_CMP;
            S_INS_CMP: state_next = dp_status.less ? S_INS_RD : S_IDLE;
            S_REM_RD:  state_next = dp_status.idx_at_count ? S_IDLE : S_REM_CMP;
            S_REM_CMP: state_next = S_REM_RD;
            S_RD_WAIT: state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.rd_sel = ADDR_IDX;
        cmd.fin_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DECODE:
            begin
                case (dp_status.action)
                    ACT_INSERT:
                    begin
                        if (dp_status.full)
                        begin
                            cmd.fin = 1'b1;
                            cmd.fin_status = ST_FULL;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        cmd.fin = 1'b0;
                    end
                    ACT_READ:
                    begin
                        if (dp_status.pos_oob)
                        begin
                            cmd.fin = 1'b1;
                            cmd.fin_status = ST_RANGE;
                        end
                        else
                        begin
                            cmd.rd_en = 1'b1;
                            cmd.rd_sel = ADDR_POS;
                        end
                    end
                    default:
                    begin
                        cmd.fin = 1'b1;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (dp_status.idx_zero)
                begin
                    cmd.wr_new = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.fin = 1'b1;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = ADDR_PREV;
                end
            end
            S_INS_CMP:
            begin
                if (dp_status.less)
                begin
                    cmd.wr_shift_up = 1'b1;
                    cmd.idx_dec = 1'b1;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.fin = 1'b1;
                end
            end
            S_REM_RD:
            begin
                if (dp_status.idx_at_count)
                begin
                    cmd.fin = 1'b1;
                    if (dp_status.found)
                    begin
                        cmd.cnt_dec = 1'b1;
                    end
                    else
                    begin
                        cmd.fin_status = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_sel = ADDR_IDX;
                end
            end
            S_REM_CMP:
            begin
                cmd.idx_inc = 1'b1;
                if (dp_status.found)
                begin
                    cmd.wr_shift_down = 1'b1;
                end
                else if (dp_status.pid_match)
                begin
                    cmd.found_set = 1'b1;
                end
            end
            S_RD_WAIT:
            begin
                cmd.fin = 1'b1;
                cmd.fin_read = 1'b1;
            end
            default:
            begin
                cmd.fin = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### rtl/srq_datapath.sv
module srq_datapath
    import srq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  request_t   request,
    input  ctrl_cmd_t  cmd,
    output dp_status_t dp_status,
    output logic       done,
    output result_t    result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 4;
    localparam int XW = CW + 5;

    logic [7:0]    mem_prio [CAPACITY];
    logic [15:0]   mem_pid  [CAPACITY];

    request_t      req_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_prev;
    logic          found_reg;
    logic [7:0]    rd_prio_reg;
    logic [15:0]   rd_pid_reg;
    logic          done_reg;
    result_t       result_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_prio;
    logic [15:0]   wr_pid;
    logic          wr_en;
    logic [PW-1:0] pos_ext;
    logic [XW-1:0] count_ext;

    assign idx_prev = idx_reg - CW'(1);
    assign pos_ext  = PW'(req_reg.position);

    always_comb
    begin
        case (cmd.rd_sel)
            ADDR_PREV: rd_addr = idx_prev[AW-1:0];
            ADDR_IDX:  rd_addr = idx_reg[AW-1:0];
            ADDR_POS:  rd_addr = pos_ext[AW-1:0];
            default:   rd_addr = idx_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        wr_en   = cmd.wr_new | cmd.wr_shift_up | cmd.wr_shift_down;
        wr_addr = cmd.wr_shift_down ? idx_prev[AW-1:0] : idx_reg[AW-1:0];
        wr_prio = cmd.wr_new ? req_reg.item_priority : rd_prio_reg;
        wr_pid  = cmd.wr_new ? req_reg.item_pid : rd_pid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_prio[wr_addr] <= wr_prio;
            mem_pid[wr_addr]  <= wr_pid;
        end
        if (cmd.rd_en)
        begin
            rd_prio_reg <= mem_prio[rd_addr];
            rd_pid_reg  <= mem_pid[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_ext = XW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.fin;
            if (cmd.load)
            begin
                idx_reg   <= (request.action == ACT_INSERT) ? count_reg : '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                else if (cmd.idx_dec)
                begin
                    idx_reg <= idx_prev;
                end
                if (cmd.found_set)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.fin)
        begin
            result_reg.status        <= cmd.fin_status;
            result_reg.read_pid      <= cmd.fin_read ? rd_pid_reg : '0;
            result_reg.read_priority <= cmd.fin_read ? rd_prio_reg : '0;
            result_reg.entry_count   <= count_ext[4:0];
        end
    end

    always_comb
    begin
        dp_status.action       = req_reg.action;
        dp_status.full         = (count_reg == CW'(CAPACITY));
        dp_status.pos_oob      = (pos_ext >= PW'(count_reg));
        dp_status.idx_zero     = (idx_reg == '0);
        dp_status.idx_at_count = (idx_reg == count_reg);
        dp_status.less         = (rd_prio_reg < req_reg.item_priority) ||
                                 ((rd_prio_reg == req_reg.item_priority) &&
                                  (rd_pid_reg < req_reg.item_pid));
        dp_status.pid_match    = (rd_pid_reg == req_reg.item_pid);
        dp_status.found        = found_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/sorted_ready_queue_unit.sv
// One request at a time; insert and remove walk the slot memory, reading one slot and
// possibly writing one per step, while a full insert or out-of-range read finishes in decode.
// A new request may start in the done cycle.
// Reset clears the count and control; slot contents are left as they are.
// The receiver cannot stall: done is high for exactly one cycle per request.
module sorted_ready_queue_unit
    import srq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    srq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy)
    );

    srq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .dp_status (dp_status),
        .done      (done),
        .result    (result)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (result.entry_count == 5'(CAPACITY)))
        else $error("full reported with wrong count");

    a_fin_one_change: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.cnt_inc && cmd.cnt_dec))
        else $error("count incremented and decremented together");

endmodule

### test/srq_checker.sv
module srq_checker
    import srq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  request_t request,
    input  logic     done,
    input  result_t  result,
    output int       mismatches,
    output int       outstanding
);

    logic [7:0]  shadow_prio [CAPACITY];
    logic [15:0] shadow_pid  [CAPACITY];
    int          shadow_count;
    result_t     awaited_results [$];
    int          error_total;

    // Applies one request to the shadow queue and returns the result it should produce.
    function automatic result_t step_queue(input request_t rq);
        result_t r;
        int      k;
        int      j;
        r = '0;
        r.status = ST_OK;
        case (rq.action)
            ACT_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    k = 0;
                    while (k < shadow_count &&
                           !(shadow_prio[k] < rq.item_priority ||
                             (shadow_prio[k] == rq.item_priority &&
                              shadow_pid[k] < rq.item_pid)))
                        k++;
                    for (j = shadow_count; j > k; j--)
                    begin
                        shadow_prio[j] = shadow_prio[j - 1];
                        shadow_pid[j]  = shadow_pid[j - 1];
                    end
                    shadow_prio[k] = rq.item_priority;
                    shadow_pid[k]  = rq.item_pid;
                    shadow_count++;
                end
            end
            ACT_REMOVE:
            begin
                k = 0;
                while (k < shadow_count && shadow_pid[k] != rq.item_pid)
                    k++;
                if (k >= shadow_count)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    for (j = k; j + 1 < shadow_count; j++)
                    begin
                        shadow_prio[j] = shadow_prio[j + 1];
                        shadow_pid[j]  = shadow_pid[j + 1];
                    end
                    shadow_count--;
                end
            end
            ACT_READ:
            begin
                if (int'(rq.position) >= shadow_count)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.read_pid      = shadow_pid[rq.position];
                    r.read_priority = shadow_prio[rq.position];
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = 5'(shadow_count);
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [15:0] exp_val,
                                 input logic [15:0] act_val);
        $error("%s: expected %h, got %h", field, exp_val, act_val);
        error_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            awaited_results.delete();
            error_total = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no request outstanding: %h", result);
                    error_total++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.status !== want.status)
                        note_mismatch("status", 16'(want.status), 16'(result.status));
                    if (result.read_pid !== want.read_pid)
                        note_mismatch("read_pid", want.read_pid, result.read_pid);
                    if (result.read_priority !== want.read_priority)
                        note_mismatch("read_priority", 16'(want.read_priority),
                                      16'(result.read_priority));
                    if (result.entry_count !== want.entry_count)
                        note_mismatch("entry_count", 16'(want.entry_count),
                                      16'(result.entry_count));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                awaited_results.push_back(step_queue(request));
            mismatches <= error_total;
            outstanding <= awaited_results.size();
        end
    end

endmodule

### test/testbench.sv
module testbench;
    import srq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int PAUSE_EVERY  = 400;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef enum int {
        EP_FILL,
        EP_GROW,
        EP_MIXED,
        EP_DRAIN
    } episode_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;
    int       mismatches;
    int       outstanding;
    int       quiet_cycles = 0;
    int       burst_left;

    sorted_ready_queue_unit #(.CAPACITY(CAPACITY)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    srq_checker #(.CAPACITY(CAPACITY)) queue_watch
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic request_t make_req(input logic [1:0] act, input logic [7:0] prio,
                                          input logic [15:0] pid, input logic [3:0] pos);
        request_t rq;
        rq.action        = act;
        rq.item_priority = prio;
        rq.item_pid      = pid;
        rq.position      = pos;
        return rq;
    endfunction

    function automatic request_t random_request(input episode_t mode);
        int          roll;
        int          ins_pct;
        int          rem_pct;
        logic [1:0]  act;
        logic [7:0]  prio;
        logic [15:0] pid;
        case (mode)
            EP_FILL:  begin ins_pct = 100; rem_pct = 0;  end
            EP_GROW:  begin ins_pct = 70;  rem_pct = 12; end
            EP_MIXED: begin ins_pct = 40;  rem_pct = 30; end
            default:  begin ins_pct = 12;  rem_pct = 65; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            act = ACT_INSERT;
        else if (roll < ins_pct + rem_pct)
            act = ACT_REMOVE;
        else if (roll < 97)
            act = ACT_READ;
        else
            act = ACT_UNUSED;
        // narrow pools make ties and remove hits common
        roll = $urandom_range(0, 9);
        if (roll < 6)
            prio = 8'(100 + $urandom_range(0, 3));
        else if (roll == 6)
            prio = 8'h00;
        else if (roll == 7)
            prio = 8'hFF;
        else
            prio = 8'($urandom);
        if ($urandom_range(0, 99) < 85)
            pid = 16'($urandom_range(0, 23) * 2731);
        else
            pid = 16'($urandom);
        return make_req(act, prio, pid, 4'($urandom_range(0, 15)));
    endfunction

    task automatic send(input request_t rq);
        int gap;
        start <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                start <= 1'b0;
                request <= make_req(2'($urandom), 8'($urandom), 16'($urandom),
                                    4'($urandom));
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        episode_t mode;
        int       ep_len;
        int       issued;
        int       next_pause;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        burst_left = 1;
        issued = 0;
        next_pause = PAUSE_EVERY;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(make_req(ACT_READ, 8'h00, 16'h0000, 4'd0));
        send(make_req(ACT_REMOVE, 8'h00, 16'h0000, 4'd0));
        send(make_req(ACT_UNUSED, 8'hFF, 16'hFFFF, 4'hF));
        send(make_req(ACT_INSERT, 8'd128, 16'h1234, 4'd0));
        send(make_req(ACT_INSERT, 8'd128, 16'h1234, 4'd0));
        send(make_req(ACT_INSERT, 8'd128, 16'h8000, 4'd0));
        send(make_req(ACT_INSERT, 8'd128, 16'h0001, 4'd0));
        send(make_req(ACT_INSERT, 8'hFF, 16'hFFFF, 4'hF));
        send(make_req(ACT_INSERT, 8'h00, 16'h0000, 4'd0));
        send(make_req(ACT_READ, 8'h00, 16'h0000, 4'd0));
        send(make_req(ACT_READ, 8'h00, 16'h0000, 4'd5));
        send(make_req(ACT_READ, 8'h00, 16'h0000, 4'd6));
        send(make_req(ACT_READ, 8'hFF, 16'hFFFF, 4'hF));
        send(make_req(ACT_REMOVE, 8'h00, 16'h1234, 4'd0));
        send(make_req(ACT_READ, 8'h00, 16'h0000, 4'd2));
        send(make_req(ACT_REMOVE, 8'h00, 16'hFFFF, 4'd0));
        send(make_req(ACT_REMOVE, 8'h00, 16'h0000, 4'd0));
        send(make_req(ACT_REMOVE, 8'h00, 16'hBEEF, 4'd0));
        send(make_req(ACT_READ, 8'h00, 16'h0000, 4'd0));
        send(make_req(ACT_UNUSED, 8'h00, 16'h0000, 4'd0));
        settle();

        while (issued < RANDOM_ITEMS)
        begin
            mode = episode_t'($urandom_range(0, 3));
            ep_len = $urandom_range(8, 40);
            repeat (ep_len)
            begin
                send(random_request(mode));
                issued++;
            end
            if (issued >= next_pause)
            begin
                settle();
                next_pause += PAUSE_EVERY;
            end
        end

        settle();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sorted_ready_queue_unit.f
rtl/srq_pkg.sv
rtl/srq_ctrl.sv
rtl/srq_datapath.sv
rtl/sorted_ready_queue_unit.sv
test/srq_checker.sv
test/testbench.sv
